// ===== rtl/rwmf_pkg.sv =====
// Shared types, register indexes and helpers for the window maximum filter.
package rwmf_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int ROWS_W     = 13;
	localparam int ROW_IDX_W  = 12;
	localparam int NCOLS_W    = 10;
	localparam int WIN_REG_W  = 5;
	localparam int ROW_LIMIT  = 4096;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

	localparam cfg_idx_t REG_NUM_ROWS = cfg_idx_t'(0);
	localparam cfg_idx_t REG_NUM_COLS = cfg_idx_t'(1);
	localparam cfg_idx_t REG_WIN_H    = cfg_idx_t'(2);
	localparam cfg_idx_t REG_WIN_W    = cfg_idx_t'(3);

	// Work handed from the stream front end to the window unit
	typedef struct packed {
		logic    col_need;
		logic    out_need;
		logic    last;
		sample_t sample;
	} job_t;

	typedef struct packed {
		sample_t window_max;
		logic    last_of_frame;
	} result_t;

	function automatic sample_t smax(input sample_t a, input sample_t b);
		return (b > a) ? b : a;
	endfunction

endpackage

// ===== rtl/rect_window_max_filter_top.sv =====
// Sliding rectangular window maximum over a streamed frame of signed samples.
// A sample outside the window rows is taken without holding the input; one in the window rows
// reads the line store once per earlier window row, and one that ends a window also scans
// the column taps before its result is registered.
// A finished result waits in the output register while the next word is taken.
// arst_n clears the registers to 1 and the frame position; the line store is not cleared.
module rect_window_max_filter_top import rwmf_pkg::*; #(
	parameter int MAX_COLS  = 512,
	parameter int MAX_WIN_H = 16,
	parameter int MAX_WIN_W = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  sample_t               sample,
	output logic                  result_valid,
	input  logic                  result_ready,
	output sample_t               window_max,
	output logic                  last_of_frame
);

	localparam int DEPTH = MAX_WIN_H * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CNT_W = $clog2(MAX_COLS + 1);
	localparam int SW    = (MAX_WIN_H > 1) ? $clog2(MAX_WIN_H) : 1;
	localparam int HW    = $clog2(MAX_WIN_H + 1);
	localparam int WCW   = $clog2(MAX_WIN_W + 1);

	logic [ROWS_W-1:0]    num_rows_q;
	logic [NCOLS_W-1:0]   num_cols_q;
	logic [WIN_REG_W-1:0] win_h_q;
	logic [WIN_REG_W-1:0] win_w_q;

	logic [ROW_IDX_W-1:0] row_q;
	logic [CW-1:0]        col_q;
	logic [SW-1:0]        slot_q;

	logic [ROWS_W-1:0] rows_eff;
	logic [CNT_W-1:0]  cols_eff;
	logic [HW-1:0]     wh_eff;
	logic [WCW-1:0]    ww_eff;
	logic [31:0]       rows_c, cols_c, wh_c, ww_c;

	logic          acc;
	logic          col_end;
	logic          row_end;
	job_t          job;
	logic [AW-1:0] wr_addr;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	sample_t       rd_data;
	logic          unit_ready;
	result_t       res;

	function automatic logic [31:0] clamp(input logic [31:0] v, input int hi);
		if (v == 32'd0) begin
			return 32'd1;
		end
		return (v > 32'(hi)) ? 32'(hi) : v;
	endfunction

	// zero acts as one, oversize saturates
	always_comb begin
		rows_c   = clamp(32'(num_rows_q), ROW_LIMIT);
		cols_c   = clamp(32'(num_cols_q), MAX_COLS);
		wh_c     = clamp(32'(win_h_q), MAX_WIN_H);
		ww_c     = clamp(32'(win_w_q), MAX_WIN_W);
		rows_eff = rows_c[ROWS_W-1:0];
		cols_eff = cols_c[CNT_W-1:0];
		wh_eff   = wh_c[HW-1:0];
		ww_eff   = ww_c[WCW-1:0];
	end

	assign acc          = sample_valid && sample_ready;
	assign sample_ready = unit_ready;
	assign col_end      = (32'(col_q) + 32'd1 == 32'(cols_eff));
	assign row_end      = (32'(row_q) + 32'd1 == 32'(rows_eff));
	assign wr_addr      = AW'(32'(slot_q) * MAX_COLS + 32'(col_q));

	always_comb begin
		job.col_need = (32'(wh_eff) <= 32'(rows_eff)) && (32'(ww_eff) <= 32'(cols_eff))
			&& (32'(row_q) + 32'd1 >= 32'(wh_eff));
		job.out_need = job.col_need && (32'(col_q) + 32'd1 >= 32'(ww_eff));
		job.last     = row_end && col_end;
		job.sample   = sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= ROWS_W'(1);
			num_cols_q <= NCOLS_W'(1);
			win_h_q    <= WIN_REG_W'(1);
			win_w_q    <= WIN_REG_W'(1);
			row_q      <= '0;
			col_q      <= '0;
			slot_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_ROWS: num_rows_q <= cfg_wdata[ROWS_W-1:0];
				REG_NUM_COLS: num_cols_q <= cfg_wdata[NCOLS_W-1:0];
				REG_WIN_H:    win_h_q    <= cfg_wdata[WIN_REG_W-1:0];
				REG_WIN_W:    win_w_q    <= cfg_wdata[WIN_REG_W-1:0];
				default: ;
			endcase
			// any valid register write restarts the frame
			if (cfg_index == REG_NUM_ROWS || cfg_index == REG_NUM_COLS ||
				cfg_index == REG_WIN_H || cfg_index == REG_WIN_W) begin
				row_q  <= '0;
				col_q  <= '0;
				slot_q <= '0;
			end
		end else if (acc) begin
			if (col_end) begin
				col_q <= '0;
				if (row_end) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_q + ROW_IDX_W'(1);
					slot_q <= (32'(slot_q) == MAX_WIN_H - 1) ? '0 : slot_q + SW'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	rwmf_line_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (acc),
		.waddr (wr_addr),
		.wdata (sample),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	rwmf_window_unit #(
		.MAX_COLS  (MAX_COLS),
		.MAX_WIN_H (MAX_WIN_H),
		.MAX_WIN_W (MAX_WIN_W)
	) u_unit (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (acc),
		.job       (job),
		.slot      (slot_q),
		.col       (col_q),
		.wh        (wh_eff),
		.ww        (ww_eff),
		.ready     (unit_ready),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.res_valid (result_valid),
		.res_ready (result_ready),
		.res       (res)
	);

	assign window_max    = res.window_max;
	assign last_of_frame = res.last_of_frame;

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == REG_WIN_W |=> row_q == '0 && col_q == '0 && slot_q == '0)
		else $error("frame position not cleared by register write");

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < 32'(cols_eff) && 32'(row_q) < 32'(rows_eff))
		else $error("frame position outside frame");

	a_skip_fast: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !job.col_need |=> sample_ready)
		else $error("sample outside window rows held the input");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(slot_q) < MAX_WIN_H)
		else $error("line store slot out of range");

endmodule

// ===== rtl/rwmf_line_store.sv =====
// Line store RAM: one write port, one read port with registered read data.
module rwmf_line_store import rwmf_pkg::*; #(
	parameter int DEPTH = 8192,
	parameter int AW    = 13
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  sample_t       wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output sample_t       rdata
);

	sample_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/rwmf_window_unit.sv =====
// Window unit: vertical column max from the line store, column-max taps,
// horizontal scan and the output register.
module rwmf_window_unit import rwmf_pkg::*; #(
	parameter int MAX_COLS  = 512,
	parameter int MAX_WIN_H = 16,
	parameter int MAX_WIN_W = 16,
	localparam int DEPTH = MAX_WIN_H * MAX_COLS,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	localparam int SW    = (MAX_WIN_H > 1) ? $clog2(MAX_WIN_H) : 1,
	localparam int HW    = $clog2(MAX_WIN_H + 1),
	localparam int WCW   = $clog2(MAX_WIN_W + 1),
	localparam int TW    = (MAX_WIN_W > 1) ? $clog2(MAX_WIN_W) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  job_t          job,
	input  logic [SW-1:0] slot,
	input  logic [CW-1:0] col,
	input  logic [HW-1:0] wh,
	input  logic [WCW-1:0] ww,
	output logic          ready,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	input  sample_t       rd_data,
	output logic          res_valid,
	input  logic          res_ready,
	output result_t       res
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_VERT = 4'b0010,
		ST_HORZ = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t         state_q;
	job_t           job_q;
	logic [SW-1:0]  rd_slot_q;
	logic [CW-1:0]  col_q;
	logic [HW-1:0]  k_q;
	logic [WCW-1:0] j_q;
	logic           pend_s1;
	sample_t        vacc_q;
	sample_t        hacc_q;
	sample_t        taps_q [MAX_WIN_W];
	logic           res_valid_q;
	result_t        res_q;
	logic           vert_done;
	logic           out_free;
	logic           horz_more;

	function automatic logic [SW-1:0] slot_dec(input logic [SW-1:0] s);
		return (s == '0) ? SW'(MAX_WIN_H - 1) : s - SW'(1);
	endfunction

	assign ready     = (state_q == ST_IDLE);
	assign rd_en     = (state_q == ST_VERT) && (k_q < wh);
	assign rd_addr   = AW'(32'(rd_slot_q) * MAX_COLS + 32'(col_q));
	assign vert_done = (k_q >= wh) && !pend_s1;
	assign out_free  = !res_valid_q || res_ready;
	assign horz_more = (j_q < ww);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_s1     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			pend_s1 <= rd_en;
			if (state_q == ST_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start && job.col_need) begin
						state_q <= ST_VERT;
					end
				end
				ST_VERT: begin
					if (vert_done) begin
						state_q <= job_q.out_need ? ST_HORZ : ST_IDLE;
					end
				end
				ST_HORZ: begin
					if (!horz_more) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					// the new sample is row zero of its own column
					job_q     <= job;
					vacc_q    <= job.sample;
					k_q       <= HW'(1);
					rd_slot_q <= slot_dec(slot);
					col_q     <= col;
				end
			end
			ST_VERT: begin
				if (rd_en) begin
					k_q       <= k_q + HW'(1);
					rd_slot_q <= slot_dec(rd_slot_q);
				end
				if (pend_s1) begin
					vacc_q <= smax(vacc_q, rd_data);
				end
				if (vert_done) begin
					for (int i = MAX_WIN_W - 1; i > 0; i--) begin
						taps_q[i] <= taps_q[i-1];
					end
					taps_q[0] <= vacc_q;
					hacc_q    <= vacc_q;
					j_q       <= WCW'(1);
				end
			end
			ST_HORZ: begin
				if (horz_more) begin
					hacc_q <= smax(hacc_q, taps_q[j_q[TW-1:0]]);
					j_q    <= j_q + WCW'(1);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					res_q.window_max    <= hacc_q;
					res_q.last_of_frame <= job_q.last;
				end
			end
			default: ;
		endcase
	end

endmodule
